[hw/rtl/cds_pkg.sv]
package cds_pkg;

  // Width of a user type handle.
  localparam int HANDLE_BITS = 16;

  // Token classes on the input mode field.
  localparam logic [4:0] MODE_QUALIFIER    = 5'd0;
  localparam logic [4:0] MODE_STORAGE_LO   = 5'd1;
  localparam logic [4:0] MODE_STORAGE_HI   = 5'd5;
  localparam logic [4:0] MODE_BASE_LO      = 5'd6;
  localparam logic [4:0] MODE_BASE_HI      = 5'd11;
  localparam logic [4:0] MODE_SIGNED       = 5'd12;
  localparam logic [4:0] MODE_UNSIGNED     = 5'd13;
  localparam logic [4:0] MODE_SHORT        = 5'd14;
  localparam logic [4:0] MODE_LONG         = 5'd15;
  localparam logic [4:0] MODE_AGGREGATE    = 5'd16;
  localparam logic [4:0] MODE_TYPEDEF_NAME = 5'd17;
  localparam logic [4:0] MODE_OTHER        = 5'd18;
  localparam logic [4:0] MODE_END          = 5'd19;

  // Offsets that turn a token class into a state code.
  localparam logic [4:0] BASE_OFFSET = 5'd5;
  localparam logic [4:0] SIGN_OFFSET = 5'd11;

  // Result status.
  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_DUP_STOR  = 3'd1;
  localparam logic [2:0] ERR_DUP_SPEC  = 3'd2;
  localparam logic [2:0] ERR_ILLEGAL   = 3'd3;
  localparam logic [2:0] ERR_LONG3     = 3'd4;
  localparam logic [2:0] ERR_EARLY_END = 3'd5;

  // Resolved type codes.
  localparam logic [3:0] TC_VOID    = 4'd0;
  localparam logic [3:0] TC_BOOL    = 4'd1;
  localparam logic [3:0] TC_CHAR    = 4'd2;
  localparam logic [3:0] TC_SHORT   = 4'd3;
  localparam logic [3:0] TC_INT     = 4'd4;
  localparam logic [3:0] TC_LONG    = 4'd5;
  localparam logic [3:0] TC_LLONG   = 4'd6;
  localparam logic [3:0] TC_FLOAT   = 4'd7;
  localparam logic [3:0] TC_DOUBLE  = 4'd8;
  localparam logic [3:0] TC_LDOUBLE = 4'd9;
  localparam logic [3:0] TC_USER    = 4'd10;

  // Base type state codes.
  localparam logic [2:0] BT_NONE   = 3'd0;
  localparam logic [2:0] BT_VOID   = 3'd1;
  localparam logic [2:0] BT_BOOL   = 3'd2;
  localparam logic [2:0] BT_CHAR   = 3'd3;
  localparam logic [2:0] BT_INT    = 3'd4;
  localparam logic [2:0] BT_FLOAT  = 3'd5;
  localparam logic [2:0] BT_DOUBLE = 3'd6;

  // Size state codes.
  localparam logic [1:0] SZ_NONE  = 2'd0;
  localparam logic [1:0] SZ_SHORT = 2'd1;
  localparam logic [1:0] SZ_LONG  = 2'd2;
  localparam logic [1:0] SZ_LLONG = 2'd3;

  // Sign state codes.
  localparam logic [1:0] SG_NONE     = 2'd0;
  localparam logic [1:0] SG_SIGNED   = 2'd1;
  localparam logic [1:0] SG_UNSIGNED = 2'd2;

  localparam logic [2:0] STOR_NONE = 3'd0;

  typedef struct packed {
    logic [4:0]             mode;
    logic [HANDLE_BITS-1:0] user_handle;
  } token_t;

  typedef struct packed {
    logic [2:0]             storage_kind;
    logic [2:0]             base_type;
    logic [1:0]             size_kind;
    logic [1:0]             sign_kind;
    logic                   user_seen;
    logic [HANDLE_BITS-1:0] user_value;
  } spec_state_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [2:0]             error_code;
    logic [3:0]             type_code;
    logic                   is_signed;
    logic [2:0]             storage_class;
    logic [HANDLE_BITS-1:0] result_handle;
  } result_t;

endpackage

[hw/rtl/cds_in_if.sv]
interface cds_in_if;
  import cds_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [4:0]             mode;
  logic [HANDLE_BITS-1:0] user_handle;

  modport source (output valid, output mode, output user_handle, input ready);
  modport sink   (input valid, input mode, input user_handle, output ready);
endinterface

[hw/rtl/cds_out_if.sv]
interface cds_out_if;
  import cds_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [2:0]             error_code;
  logic [3:0]             type_code;
  logic                   is_signed;
  logic [2:0]             storage_class;
  logic [HANDLE_BITS-1:0] result_handle;

  modport source (output valid, output status, output error_code, output type_code,
                  output is_signed, output storage_class, output result_handle,
                  input ready);
  modport sink   (input valid, input status, input error_code, input type_code,
                  input is_signed, input storage_class, input result_handle,
                  output ready);
endinterface

[hw/rtl/c_decl_specifier_checker.sv]
// A token accepted on in_ch is held in the input register until the result register is free,
// then its result is registered there and presented on out_ch.
// Throughput: one token per cycle while out_ch is ready, set by a single pass of the check
// logic between the input and result registers; the specifier state is updated in that pass.
// Reset (rst_n low, synchronous): both register stages empty and the specifier state cleared.
module c_decl_specifier_checker (
  input logic      clk,
  input logic      rst_n,
  cds_in_if.sink   in_ch,
  cds_out_if.source out_ch
);
  import cds_pkg::*;

  // Input register stage. It holds one request until the result stage can take it.
  logic        in_valid_r;
  token_t      in_tok_r;

  // Accumulated declaration specifier. It advances only when a request moves into the
  // result stage, so consecutive tokens always see the state left by the one before.
  spec_state_t state_r;
  spec_state_t state_nxt;

  // Result register stage.
  logic        out_valid_r;
  result_t     out_res_r;
  result_t     eval_res;

  logic        out_free;
  logic        advance;
  logic        in_take;

  // The result stage is free when empty or being drained this cycle; the input stage
  // can then take a new request in the same cycle that it hands its own one onward.
  assign out_free = !out_valid_r || out_ch.ready;
  assign advance  = in_valid_r && out_free;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !in_valid_r || advance;

  cds_eval u_eval (
    .cur_state (state_r),
    .token     (in_tok_r),
    .nxt_state (state_nxt),
    .result    (eval_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers carry no reset; the valid flags qualify them.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_tok_r.mode        <= in_ch.mode;
      in_tok_r.user_handle <= in_ch.user_handle;
    end
    if (advance) begin
      out_res_r <= eval_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.error_code    = out_res_r.error_code;
  assign out_ch.type_code     = out_res_r.type_code;
  assign out_ch.is_signed     = out_res_r.is_signed;
  assign out_ch.storage_class = out_res_r.storage_class;
  assign out_ch.result_handle = out_res_r.result_handle;

  // With the result stage empty, the input side must never stall.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled while result stage empty");

  // A finished or failed specifier leaves the state fully cleared.
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (eval_res.status == ST_DONE || eval_res.status == ST_ERROR) |=>
    state_r == '0)
    else $error("specifier state not cleared after end or error");

  // An error result always carries a code, and only an error result does.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_res_r.status == ST_ERROR) == (out_res_r.error_code != ERR_NONE)))
    else $error("error code does not match status");

  // Only a finished specifier reports type, storage class and handle.
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status != ST_DONE |->
    out_res_r.type_code == TC_VOID && out_res_r.storage_class == STOR_NONE &&
    out_res_r.result_handle == '0 && !out_res_r.is_signed)
    else $error("result fields set without a finished specifier");

endmodule

[hw/rtl/cds_eval.sv]
module cds_eval (
  input  cds_pkg::spec_state_t cur_state,
  input  cds_pkg::token_t      token,
  output cds_pkg::spec_state_t nxt_state,
  output cds_pkg::result_t     result
);
  import cds_pkg::*;

  // True when the accumulated specifiers form an illegal combination.
  function automatic logic combo_bad(input spec_state_t s);
    logic bad;
    bad = 1'b0;
    if (s.base_type == BT_BOOL && (s.size_kind != SZ_NONE || s.sign_kind != SG_NONE))
      bad = 1'b1;
    if (s.size_kind == SZ_SHORT && s.base_type != BT_NONE && s.base_type != BT_INT)
      bad = 1'b1;
    if (s.size_kind == SZ_LONG && s.base_type != BT_NONE && s.base_type != BT_INT &&
        s.base_type != BT_DOUBLE)
      bad = 1'b1;
    if (s.size_kind == SZ_LLONG && s.base_type != BT_NONE && s.base_type != BT_INT)
      bad = 1'b1;
    if (s.sign_kind != SG_NONE && (s.base_type == BT_VOID || s.base_type == BT_FLOAT ||
                                   s.base_type == BT_DOUBLE))
      bad = 1'b1;
    if (s.user_seen && (s.base_type != BT_NONE || s.size_kind != SZ_NONE ||
                        s.sign_kind != SG_NONE))
      bad = 1'b1;
    return bad;
  endfunction

  logic [4:0]  mode_eff;
  logic [4:0]  base_diff;
  logic [4:0]  sign_diff;
  spec_state_t cand;
  logic        check;
  logic [2:0]  err;
  logic        finish;
  logic [3:0]  tc;
  logic        sg;

  assign base_diff = token.mode - BASE_OFFSET;
  assign sign_diff = token.mode - SIGN_OFFSET;

  always_comb begin
    // A typedef name after a user type ends the specifier.
    mode_eff = token.mode;
    if (token.mode == MODE_TYPEDEF_NAME && cur_state.user_seen) begin
      mode_eff = MODE_OTHER;
    end

    cand   = cur_state;
    check  = 1'b0;
    err    = ERR_NONE;
    finish = 1'b0;

    priority if (mode_eff >= MODE_STORAGE_LO && mode_eff <= MODE_STORAGE_HI) begin
      if (cur_state.storage_kind != STOR_NONE) begin
        err = ERR_DUP_STOR;
      end else begin
        cand.storage_kind = mode_eff[2:0];
      end
    end else if (mode_eff >= MODE_BASE_LO && mode_eff <= MODE_BASE_HI) begin
      if (cur_state.base_type != BT_NONE) begin
        err = ERR_DUP_SPEC;
      end else begin
        cand.base_type = base_diff[2:0];
        check = 1'b1;
      end
    end else if (mode_eff == MODE_SIGNED || mode_eff == MODE_UNSIGNED) begin
      if (cur_state.sign_kind != SG_NONE) begin
        err = ERR_DUP_SPEC;
      end else begin
        cand.sign_kind = sign_diff[1:0];
        check = 1'b1;
      end
    end else if (mode_eff == MODE_SHORT) begin
      if (cur_state.size_kind != SZ_NONE) begin
        err = ERR_DUP_SPEC;
      end else begin
        cand.size_kind = SZ_SHORT;
        check = 1'b1;
      end
    end else if (mode_eff == MODE_LONG) begin
      unique case (cur_state.size_kind)
        SZ_NONE: begin
          cand.size_kind = SZ_LONG;
          check = 1'b1;
        end
        SZ_LONG: begin
          cand.size_kind = SZ_LLONG;
          check = 1'b1;
        end
        SZ_LLONG: err = ERR_LONG3;
        default:  err = ERR_ILLEGAL;
      endcase
    end else if (mode_eff == MODE_AGGREGATE || mode_eff == MODE_TYPEDEF_NAME) begin
      if (cur_state.user_seen) begin
        err = ERR_DUP_SPEC;
      end else begin
        cand.user_seen  = 1'b1;
        cand.user_value = token.user_handle;
        check = 1'b1;
      end
    end else if (mode_eff == MODE_OTHER) begin
      finish = 1'b1;
    end else if (mode_eff == MODE_END) begin
      err = ERR_EARLY_END;
    end else begin
      // Qualifiers and unused classes leave the state alone.
    end

    if (check && combo_bad(cand)) begin
      err = ERR_ILLEGAL;
    end
  end

  // Type resolution for an ending token.
  always_comb begin
    tc = TC_INT;
    sg = (cur_state.sign_kind != SG_UNSIGNED);
    priority if (cur_state.user_seen) begin
      tc = TC_USER;
      sg = 1'b0;
    end else if (cur_state.base_type == BT_VOID) begin
      tc = TC_VOID;
      sg = 1'b0;
    end else if (cur_state.base_type == BT_BOOL) begin
      tc = TC_BOOL;
      sg = 1'b0;
    end else if (cur_state.base_type == BT_CHAR) begin
      tc = TC_CHAR;
    end else if (cur_state.base_type == BT_FLOAT) begin
      tc = TC_FLOAT;
      sg = 1'b0;
    end else if (cur_state.base_type == BT_DOUBLE) begin
      tc = (cur_state.size_kind == SZ_LONG) ? TC_LDOUBLE : TC_DOUBLE;
      sg = 1'b0;
    end else if (cur_state.size_kind == SZ_SHORT) begin
      tc = TC_SHORT;
    end else if (cur_state.size_kind == SZ_LONG) begin
      tc = TC_LONG;
    end else if (cur_state.size_kind == SZ_LLONG) begin
      tc = TC_LLONG;
    end else begin
      tc = TC_INT;
    end
  end

  always_comb begin
    result    = '0;
    nxt_state = cand;
    if (finish) begin
      result.status        = ST_DONE;
      result.type_code     = tc;
      result.is_signed     = sg;
      result.storage_class = cur_state.storage_kind;
      result.result_handle = cur_state.user_seen ? cur_state.user_value : '0;
      nxt_state            = '0;
    end else if (err != ERR_NONE) begin
      result.status     = ST_ERROR;
      result.error_code = err;
      nxt_state         = '0;
    end
  end

endmodule

[verif/c_decl_specifier_checker_test.sv]
`timescale 1ns / 1ps

module c_decl_specifier_checker_test;
  import cds_pkg::*;

  // A mode value past the end of the defined token classes. The block must
  // treat it like a qualifier.
  localparam logic [4:0] MODE_UNUSED_TOP = 5'd31;

  // Requests that the generator counts toward the run length.
  localparam int TARGET_TOKENS = 850;

  // One queued request, plus a flag that makes the driver wait for every
  // outstanding verdict before it presents this request.
  typedef struct {
    token_t tok;
    bit     hold;
  } pending_t;

  logic clk;
  logic rst_n;

  cds_in_if  in_ch();
  cds_out_if out_ch();

  c_decl_specifier_checker u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  pending_t token_q[$];
  result_t  verdict_q[$];

  // Specifier state as the checker should hold it after each accepted token.
  logic [2:0]             held_storage = STOR_NONE;
  logic [2:0]             held_base    = BT_NONE;
  logic [1:0]             held_size    = SZ_NONE;
  logic [1:0]             held_sign    = SG_NONE;
  logic                   held_user    = 1'b0;
  logic [HANDLE_BITS-1:0] held_handle  = '0;

  int counted_tokens = 0;
  int tokens_taken   = 0;
  int results_seen   = 0;
  int done_seen      = 0;
  int fault_count    = 0;
  int err_tally[8];

  int send_gap   = 0;
  int recv_stall = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  function automatic logic [4:0] base_mode(input logic [2:0] bt);
    return BASE_OFFSET + 5'(bt);
  endfunction

  function automatic logic [4:0] sign_mode(input logic [1:0] sg);
    return SIGN_OFFSET + 5'(sg);
  endfunction

  function automatic void drop_spec();
    held_storage = STOR_NONE;
    held_base    = BT_NONE;
    held_size    = SZ_NONE;
    held_sign    = SG_NONE;
    held_user    = 1'b0;
    held_handle  = '0;
  endfunction

  // The combination rules, applied after a type specifier has been merged in.
  function automatic logic [2:0] combo_error();
    if (held_base == BT_BOOL && (held_size != SZ_NONE || held_sign != SG_NONE))
      return ERR_ILLEGAL;
    if (held_size == SZ_SHORT && held_base != BT_NONE && held_base != BT_INT)
      return ERR_ILLEGAL;
    if (held_size == SZ_LONG && held_base != BT_NONE && held_base != BT_INT &&
        held_base != BT_DOUBLE)
      return ERR_ILLEGAL;
    if (held_size == SZ_LLONG && held_base != BT_NONE && held_base != BT_INT)
      return ERR_ILLEGAL;
    if (held_sign != SG_NONE &&
        (held_base == BT_VOID || held_base == BT_FLOAT || held_base == BT_DOUBLE))
      return ERR_ILLEGAL;
    if (held_user && (held_base != BT_NONE || held_size != SZ_NONE || held_sign != SG_NONE))
      return ERR_ILLEGAL;
    return ERR_NONE;
  endfunction

  // Works out the verdict for one token and advances the held specifier state.
  function automatic result_t judge_token(input token_t t);
    result_t    r;
    logic [4:0] m;
    logic [2:0] err;
    r   = '0;
    err = ERR_NONE;
    m   = t.mode;
    // A typedef name that follows a user type is the declarator, so it ends
    // the specifier.
    if (m == MODE_TYPEDEF_NAME && held_user)
      m = MODE_OTHER;
    if (m >= MODE_STORAGE_LO && m <= MODE_STORAGE_HI) begin
      if (held_storage != STOR_NONE)
        err = ERR_DUP_STOR;
      else
        held_storage = m[2:0];
    end else if (m >= MODE_BASE_LO && m <= MODE_BASE_HI) begin
      if (held_base != BT_NONE) begin
        err = ERR_DUP_SPEC;
      end else begin
        held_base = 3'(m - BASE_OFFSET);
        err = combo_error();
      end
    end else if (m == MODE_SIGNED || m == MODE_UNSIGNED) begin
      if (held_sign != SG_NONE) begin
        err = ERR_DUP_SPEC;
      end else begin
        held_sign = 2'(m - SIGN_OFFSET);
        err = combo_error();
      end
    end else if (m == MODE_SHORT) begin
      if (held_size != SZ_NONE) begin
        err = ERR_DUP_SPEC;
      end else begin
        held_size = SZ_SHORT;
        err = combo_error();
      end
    end else if (m == MODE_LONG) begin
      // Long promotes none to long and long to long long; a third long is
      // rejected with its own code, and short long as an illegal combination.
      if (held_size == SZ_NONE) begin
        held_size = SZ_LONG;
        err = combo_error();
      end else if (held_size == SZ_LONG) begin
        held_size = SZ_LLONG;
        err = combo_error();
      end else if (held_size == SZ_LLONG) begin
        err = ERR_LONG3;
      end else begin
        err = ERR_ILLEGAL;
      end
    end else if (m == MODE_AGGREGATE || m == MODE_TYPEDEF_NAME) begin
      if (held_user) begin
        err = ERR_DUP_SPEC;
      end else begin
        held_user   = 1'b1;
        held_handle = t.user_handle;
        err = combo_error();
      end
    end else if (m == MODE_OTHER) begin
      // Resolve the type. With no base type and no size the result is int, and a
      // missing sign means signed for char and the integer types.
      r.status        = ST_DONE;
      r.type_code     = TC_INT;
      r.is_signed     = (held_sign != SG_UNSIGNED);
      r.storage_class = held_storage;
      if (held_user) begin
        r.type_code     = TC_USER;
        r.is_signed     = 1'b0;
        r.result_handle = held_handle;
      end else begin
        case (held_base)
          BT_VOID: begin
            r.type_code = TC_VOID;
            r.is_signed = 1'b0;
          end
          BT_BOOL: begin
            r.type_code = TC_BOOL;
            r.is_signed = 1'b0;
          end
          BT_CHAR: begin
            r.type_code = TC_CHAR;
          end
          BT_FLOAT: begin
            r.type_code = TC_FLOAT;
            r.is_signed = 1'b0;
          end
          BT_DOUBLE: begin
            r.type_code = (held_size == SZ_LONG) ? TC_LDOUBLE : TC_DOUBLE;
            r.is_signed = 1'b0;
          end
          default: begin
            if (held_size == SZ_SHORT)
              r.type_code = TC_SHORT;
            else if (held_size == SZ_LONG)
              r.type_code = TC_LONG;
            else if (held_size == SZ_LLONG)
              r.type_code = TC_LLONG;
          end
        endcase
      end
      drop_spec();
    end else if (m == MODE_END) begin
      err = ERR_EARLY_END;
    end
    // Qualifiers and the unused modes fall through with no effect.
    if (err != ERR_NONE) begin
      r.status     = ST_ERROR;
      r.error_code = err;
      drop_spec();
    end
    return r;
  endfunction

  task automatic queue_token(input logic [4:0] m, input logic [HANDLE_BITS-1:0] h,
                             input bit hold);
    pending_t p;
    p.tok.mode        = m;
    p.tok.user_handle = h;
    p.hold            = hold;
    token_q.push_back(p);
    counted_tokens++;
  endtask

  // Builds one declaration specifier of a legal shape, in shuffled order, with
  // random handles and qualifiers mixed in. Now and then a stray token is
  // inserted or the ending token is left off, so that broken sequences and
  // sequences that run into each other appear as well.
  task automatic queue_spec(input bit hold_first);
    logic [4:0] parts[$];
    logic [4:0] t;
    bit         user;
    int         j;
    user = 1'b0;
    case ($urandom_range(0, 7))
      0: parts.push_back(base_mode(BT_VOID));
      1: parts.push_back(base_mode(BT_BOOL));
      2: begin
        parts.push_back(base_mode(BT_CHAR));
        if ($urandom_range(0, 1))
          parts.push_back(sign_mode($urandom_range(0, 1) ? SG_SIGNED : SG_UNSIGNED));
      end
      3: begin
        if ($urandom_range(0, 1))
          parts.push_back(base_mode(BT_INT));
        if ($urandom_range(0, 1))
          parts.push_back(sign_mode($urandom_range(0, 1) ? SG_SIGNED : SG_UNSIGNED));
        case ($urandom_range(0, 3))
          1: parts.push_back(MODE_SHORT);
          2: parts.push_back(MODE_LONG);
          3: begin
            parts.push_back(MODE_LONG);
            parts.push_back(MODE_LONG);
          end
          default: ;
        endcase
      end
      4: parts.push_back(base_mode(BT_FLOAT));
      5: begin
        parts.push_back(base_mode(BT_DOUBLE));
        if ($urandom_range(0, 1))
          parts.push_back(MODE_LONG);
      end
      6: begin
        user = 1'b1;
        parts.push_back($urandom_range(0, 1) ? MODE_AGGREGATE : MODE_TYPEDEF_NAME);
      end
      default: ;
    endcase
    if ($urandom_range(0, 4) < 3)
      parts.push_back(5'($urandom_range(MODE_STORAGE_LO, MODE_STORAGE_HI)));
    repeat ($urandom_range(0, 2))
      parts.push_back(MODE_QUALIFIER);
    for (int i = parts.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = parts[i];
      parts[i] = parts[j];
      parts[j] = t;
    end
    if ($urandom_range(0, 6) == 0)
      parts.insert($urandom_range(0, parts.size()), 5'($urandom_range(0, 31)));
    if ($urandom_range(0, 11) != 0)
      parts.push_back((user && $urandom_range(0, 1)) ? MODE_TYPEDEF_NAME : MODE_OTHER);
    foreach (parts[i])
      queue_token(parts[i], HANDLE_BITS'($urandom), hold_first && i == 0);
  endtask

  function automatic void note_fault(input string why);
    fault_count++;
    if (fault_count <= 10)
      $display("ERROR @%0t: %s", $time, why);
  endfunction

  // Driver. A new request goes out only once the previous one has been taken.
  // The gap before each request is drawn per request, and bursts with no gap
  // switch on and off at random. A request marked hold waits until every
  // verdict already owed has come back.
  always @(posedge clk) begin : drive
    pending_t nxt;
    bit       fire;
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.mode        <= MODE_QUALIFIER;
      in_ch.user_handle <= '0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        verdict_q.push_back(judge_token({in_ch.mode, in_ch.user_handle}));
        tokens_taken++;
      end
      if (fire || !in_ch.valid) begin
        if (send_gap != 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (token_q.size() != 0 && !(token_q[0].hold && verdict_q.size() != 0)) begin
          nxt = token_q.pop_front();
          in_ch.mode        <= nxt.tok.mode;
          in_ch.user_handle <= nxt.tok.user_handle;
          in_ch.valid       <= 1'b1;
          send_gap = send_burst ? 0 : $urandom_range(0, 7);
          if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every verdict taken is checked against the oldest one owed. After
  // each verdict, ready drops for a drawn number of cycles, again with bursts
  // of no stall.
  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.status, out_ch.error_code, out_ch.type_code, out_ch.is_signed,
               out_ch.storage_class, out_ch.result_handle};
        results_seen++;
        if (verdict_q.size() == 0) begin
          note_fault($sformatf("verdict %0d arrived with none owed (st=%0d err=%0d tc=%0d)",
                               results_seen, got.status, got.error_code, got.type_code));
        end else begin
          want = verdict_q.pop_front();
          if (got.status != want.status || got.error_code !== want.error_code ||
              got.type_code !== want.type_code || got.is_signed !== want.is_signed ||
              got.storage_class !== want.storage_class ||
              got.result_handle !== want.result_handle || $isunknown(got))
            note_fault($sformatf({"verdict %0d: want st=%0d err=%0d tc=%0d sg=%0d sc=%0d",
                                  " h=%h, got st=%0d err=%0d tc=%0d sg=%0d sc=%0d h=%h"},
                                 results_seen, want.status, want.error_code,
                                 want.type_code, want.is_signed, want.storage_class,
                                 want.result_handle, got.status, got.error_code,
                                 got.type_code, got.is_signed, got.storage_class,
                                 got.result_handle));
          if (want.status == ST_DONE)
            done_seen++;
          err_tally[want.error_code]++;
        end
        recv_stall = recv_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 39) == 0)
          recv_burst = !recv_burst;
      end else if (recv_stall != 0) begin
        recv_stall--;
      end
      out_ch.ready <= (recv_stall == 0);
    end
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_QUALIFIER;
    in_ch.user_handle = '0;
    out_ch.ready      = 1'b0;
    foreach (err_tally[i])
      err_tally[i] = 0;

    // Directed requests. A qualifier alone resolves to a plain signed int.
    queue_token(MODE_QUALIFIER, '1, 1'b0);
    queue_token(MODE_OTHER, '0, 1'b0);
    // An unused mode is ignored; the second storage class is a duplicate.
    queue_token(MODE_UNUSED_TOP, '1, 1'b0);
    queue_token(MODE_STORAGE_HI, '0, 1'b0);
    queue_token(MODE_STORAGE_LO, '0, 1'b0);
    // Bool with a sign is illegal.
    queue_token(base_mode(BT_BOOL), '0, 1'b0);
    queue_token(sign_mode(SG_SIGNED), '0, 1'b0);
    // A third long.
    queue_token(MODE_LONG, '0, 1'b0);
    queue_token(MODE_LONG, '0, 1'b0);
    queue_token(MODE_LONG, '0, 1'b0);
    // Long after short.
    queue_token(MODE_SHORT, '0, 1'b0);
    queue_token(MODE_LONG, '0, 1'b0);
    // Long double.
    queue_token(base_mode(BT_DOUBLE), '0, 1'b0);
    queue_token(MODE_LONG, '0, 1'b0);
    queue_token(MODE_OTHER, '0, 1'b0);
    // Unsigned char.
    queue_token(sign_mode(SG_UNSIGNED), '0, 1'b0);
    queue_token(base_mode(BT_CHAR), '0, 1'b0);
    queue_token(MODE_OTHER, '0, 1'b0);
    // A typedef name after an aggregate ends the specifier with the first handle.
    queue_token(MODE_AGGREGATE, '1, 1'b0);
    queue_token(MODE_TYPEDEF_NAME, '0, 1'b0);
    // A user type mixed with a base type.
    queue_token(MODE_TYPEDEF_NAME, '0, 1'b0);
    queue_token(base_mode(BT_INT), '1, 1'b0);
    // Two base types.
    queue_token(base_mode(BT_VOID), '0, 1'b0);
    queue_token(base_mode(BT_FLOAT), '0, 1'b0);
    // An end token with no specifier pending, reported as an early end.
    queue_token(MODE_END, '1, 1'b0);

    // Random part: mostly well-formed specifiers, the rest loose tokens of any
    // mode. The first random specifier, and a few later ones, wait for the
    // checker to drain completely before they start.
    queue_spec(1'b1);
    while (counted_tokens < TARGET_TOKENS) begin
      if ($urandom_range(0, 4) != 0) begin
        queue_spec($urandom_range(0, 149) == 0);
      end else begin
        repeat ($urandom_range(1, 3))
          queue_token(5'($urandom_range(0, 31)), HANDLE_BITS'($urandom), 1'b0);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the driver to run dry and every owed verdict to arrive, then
    // leave a few cycles for anything unexpected to show up.
    while (token_q.size() != 0 || in_ch.valid || verdict_q.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Checked %0d requests giving %0d verdicts: %0d specifiers resolved.",
             tokens_taken, results_seen, done_seen);
    $display("Errors by code: dup storage %0d, dup spec %0d, illegal %0d, long %0d, end %0d.",
             err_tally[ERR_DUP_STOR], err_tally[ERR_DUP_SPEC], err_tally[ERR_ILLEGAL],
             err_tally[ERR_LONG3], err_tally[ERR_EARLY_END]);
    if (fault_count == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total.", fault_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog. A correct run ends far sooner than this.
  initial begin
    #2000000;
    $display("Timed out with %0d requests queued and %0d verdicts owed.",
             token_q.size(), verdict_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[c_decl_specifier_checker.f]
hw/rtl/cds_pkg.sv
hw/rtl/cds_in_if.sv
hw/rtl/cds_out_if.sv
hw/rtl/cds_eval.sv
hw/rtl/c_decl_specifier_checker.sv
verif/c_decl_specifier_checker_test.sv
